FILE: sv/vtp_pkg.sv
// Shared types, codes and the command letter table of the VT52 escape parser.
`default_nettype none
package vtp_pkg;

  localparam int unsigned CHAR_W   = 7;
  localparam int unsigned CMD_W    = 4;
  localparam int unsigned ROW_W    = 5;
  localparam int unsigned COL_W    = 7;
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned IN_W     = 8;
  localparam int unsigned OUT_W    = 24;
  localparam int unsigned APB_AW   = 3;
  localparam int unsigned APB_DW   = 32;

  // Register indexes on the configuration port
  localparam logic REG_EXECUTE_CONTROLS = 1'b0;

  localparam logic [CHAR_W-1:0] CH_SPACE   = 7'h20;
  localparam logic [CHAR_W-1:0] CH_ESC     = 7'h1b;
  localparam logic [CHAR_W-1:0] CH_DEL     = 7'h7f;
  localparam logic [CHAR_W-1:0] CH_LT      = 7'h3c;  // '<'
  localparam logic [CHAR_W-1:0] CH_Z       = 7'h5a;  // 'Z'
  localparam logic [CHAR_W-1:0] CH_ROW_MAX = 7'h37;  // '7'
  localparam logic [CHAR_W-1:0] CH_COL_MAX = 7'h6f;  // 'o'
  localparam logic [CHAR_W-1:0] ADDR_BIAS  = 7'd31;

  typedef enum logic [KIND_W-1:0] {
    KIND_PRINT   = 3'd0,
    KIND_CTRL_EX = 3'd1,
    KIND_CTRL_DS = 3'd2,
    KIND_COMMAND = 3'd3,
    KIND_CURSOR  = 3'd4
  } kind_e;

  typedef enum logic [3:0] {
    ST_NORMAL = 4'b0001,
    ST_ESCAPE = 4'b0010,
    ST_ROW    = 4'b0100,
    ST_COLUMN = 4'b1000
  } parse_e;

  localparam logic [CMD_W-1:0] CMD_VT100     = 4'd0;
  localparam logic [CMD_W-1:0] CMD_ALT_KP    = 4'd1;
  localparam logic [CMD_W-1:0] CMD_NORM_KP   = 4'd2;
  localparam logic [CMD_W-1:0] CMD_UP        = 4'd3;
  localparam logic [CMD_W-1:0] CMD_DOWN      = 4'd4;
  localparam logic [CMD_W-1:0] CMD_RIGHT     = 4'd5;
  localparam logic [CMD_W-1:0] CMD_LEFT      = 4'd6;
  localparam logic [CMD_W-1:0] CMD_GFX_ON    = 4'd7;
  localparam logic [CMD_W-1:0] CMD_GFX_OFF   = 4'd8;
  localparam logic [CMD_W-1:0] CMD_HOME      = 4'd9;
  localparam logic [CMD_W-1:0] CMD_REV_LF    = 4'd10;
  localparam logic [CMD_W-1:0] CMD_ERASE_EOS = 4'd11;
  localparam logic [CMD_W-1:0] CMD_ERASE_EOL = 4'd12;
  localparam logic [CMD_W-1:0] CMD_IDENTIFY  = 4'd13;
  localparam logic [CMD_W-1:0] CMD_NOP       = 4'd14;
  localparam logic [CMD_W-1:0] CMD_ADDRESS   = 4'd15;

  typedef struct packed {
    kind_e             kind;
    logic [CHAR_W-1:0] char_code;
    logic [CMD_W-1:0]  command;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  column;
  } result_t;

  // Command for each letter from '<' up, indexed by the offset from '<'
  function automatic logic [CMD_W-1:0] letter_cmd(input logic [4:0] idx);
    logic [CMD_W-1:0] cmd;
    case (idx)
      5'd0:    cmd = CMD_VT100;
      5'd1:    cmd = CMD_ALT_KP;
      5'd2:    cmd = CMD_NORM_KP;
      5'd5:    cmd = CMD_UP;
      5'd6:    cmd = CMD_DOWN;
      5'd7:    cmd = CMD_RIGHT;
      5'd8:    cmd = CMD_LEFT;
      5'd10:   cmd = CMD_GFX_ON;
      5'd11:   cmd = CMD_GFX_OFF;
      5'd12:   cmd = CMD_HOME;
      5'd13:   cmd = CMD_REV_LF;
      5'd14:   cmd = CMD_ERASE_EOS;
      5'd15:   cmd = CMD_ERASE_EOL;
      5'd29:   cmd = CMD_ADDRESS;
      5'd30:   cmd = CMD_IDENTIFY;
      default: cmd = CMD_NOP;
    endcase
    return cmd;
  endfunction

endpackage
`default_nettype wire

FILE: sv/vtp_cfg_regs.sv
// APB register block holding the control character mode.
`default_nettype none
module vtp_cfg_regs import vtp_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  output logic                   execute_controls_o
);

  logic exec_q, exec_d;
  logic reg_idx;

  assign reg_idx = paddr[2];
  assign pready  = 1'b1;

  always_comb begin
    exec_d = exec_q;
    if (psel && penable && pwrite && (reg_idx == REG_EXECUTE_CONTROLS)) begin
      exec_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exec_q <= 1'b1;
    end else begin
      exec_q <= exec_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_EXECUTE_CONTROLS) begin
      prdata = {{(APB_DW-1){1'b0}}, exec_q};
    end
  end

  assign execute_controls_o = exec_q;

endmodule
`default_nettype wire

FILE: sv/vtp_decoder.sv
// Parse state machine: classifies one character and tracks escape progress.
`default_nettype none
module vtp_decoder import vtp_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [CHAR_W-1:0] char_i,
  input  wire logic              execute_controls_i,
  input  wire logic              advance_i,
  output logic                   emit_o,
  output result_t                result_o
);

  parse_e           state_q, state_d;
  logic [ROW_W-1:0] held_row_q, held_row_d;
  logic [CHAR_W-1:0] row_clamp, col_clamp, row_sum, letter_off;
  logic [CMD_W-1:0] cmd;

  assign row_clamp  = (char_i > CH_ROW_MAX) ? CH_ROW_MAX : char_i;
  assign col_clamp  = (char_i > CH_COL_MAX) ? CH_COL_MAX : char_i;
  assign row_sum    = row_clamp - ADDR_BIAS;
  assign letter_off = char_i - CH_LT;
  assign cmd        = letter_cmd(letter_off[4:0]);

  always_comb begin
    state_d    = state_q;
    held_row_d = held_row_q;
    emit_o     = 1'b0;
    result_o   = '{kind: KIND_PRINT, char_code: '0, command: '0, row: '0, column: '0};
    if (char_i < CH_SPACE) begin
      // Controls never disturb an escape; only an executed ESC in text starts one
      emit_o             = 1'b1;
      result_o.char_code = char_i;
      if (execute_controls_i) begin
        result_o.kind = KIND_CTRL_EX;
        if ((char_i == CH_ESC) && (state_q == ST_NORMAL)) begin
          state_d = ST_ESCAPE;
        end
      end else begin
        result_o.kind = KIND_CTRL_DS;
      end
    end else begin
      case (state_q)
        ST_NORMAL: begin
          emit_o             = (char_i != CH_DEL);
          result_o.char_code = char_i;
        end
        ST_ESCAPE: begin
          state_d = ST_NORMAL;
          if ((char_i >= CH_LT) && (char_i <= CH_Z)) begin
            if (cmd == CMD_ADDRESS) begin
              state_d = ST_ROW;
            end else begin
              emit_o           = 1'b1;
              result_o.kind    = KIND_COMMAND;
              result_o.command = cmd;
            end
          end
        end
        ST_ROW: begin
          held_row_d = row_sum[ROW_W-1:0];
          state_d    = ST_COLUMN;
        end
        ST_COLUMN: begin
          state_d         = ST_NORMAL;
          emit_o          = 1'b1;
          result_o.kind   = KIND_CURSOR;
          result_o.row    = held_row_q;
          result_o.column = col_clamp - ADDR_BIAS;
        end
        default: begin
          state_d = ST_NORMAL;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_NORMAL;
      held_row_q <= '0;
    end else if (advance_i) begin
      state_q    <= state_d;
      held_row_q <= held_row_d;
    end
  end

endmodule
`default_nettype wire

FILE: sv/vtp_out_stage.sv
// Result register on the master side, refilled in the cycle it is drained.
`default_nettype none
module vtp_out_stage import vtp_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               load_i,
  input  wire result_t            result_i,
  output logic                    free_o,
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic      [OUT_W-1:0]   m_axis_tdata,   // char_code, command, row, column
  output logic      [KIND_W-1:0]  m_axis_tuser    // kind
);

  logic    valid_q, valid_d;
  result_t data_q;

  assign free_o = !valid_q || m_axis_tready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (m_axis_tready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tuser  = data_q.kind;
  assign m_axis_tdata  = {{(OUT_W-CHAR_W-CMD_W-ROW_W-COL_W){1'b0}},
                          data_q.column, data_q.row, data_q.command, data_q.char_code};

endmodule
`default_nettype wire

FILE: sv/vt52_escape_parser.sv
// VT52 escape parser: input register, combinational decoder, then result register.
// Throughput one byte per cycle; the input register refills while the result
// register drains, so only a stalled result register holds the input side.
// Bytes with no result (DEL, a non-command byte after ESC, 'Y', row bytes) never stall.
// Reset: parser in text state, held row zero, control characters executed.
`default_nettype none
module vt52_escape_parser import vtp_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [IN_W-1:0]    s_axis_tdata,   // rx_byte
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic      [OUT_W-1:0]   m_axis_tdata,   // char_code, command, row, column
  output logic      [KIND_W-1:0]  m_axis_tuser,   // kind
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [APB_AW-1:0]  paddr,
  input  wire logic [APB_DW-1:0]  pwdata,
  output logic      [APB_DW-1:0]  prdata,
  output logic                    pready
);

  logic              in_valid_q, in_valid_d;
  logic [CHAR_W-1:0] in_char_q;
  logic              exec_ctrl;
  logic              emit, out_free, advance;
  result_t           result;

  vtp_cfg_regs u_cfg (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .execute_controls_o (exec_ctrl)
  );

  // Move the held byte on unless its result has nowhere to go
  assign advance       = in_valid_q && (!emit || out_free);
  assign s_axis_tready = !in_valid_q || advance;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tvalid && s_axis_tready) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  // Strip bit 7 on capture
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_char_q <= s_axis_tdata[CHAR_W-1:0];
    end
  end

  vtp_decoder u_dec (
    .clk_i,
    .rst_ni,
    .char_i             (in_char_q),
    .execute_controls_i (exec_ctrl),
    .advance_i          (advance),
    .emit_o             (emit),
    .result_o           (result)
  );

  vtp_out_stage u_out (
    .clk_i,
    .rst_ni,
    .load_i   (advance && emit),
    .result_i (result),
    .free_o   (out_free),
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser
  );

endmodule
`default_nettype wire

FILE: tb/vt52_escape_parser_tb.sv
// Self-checking testbench for the VT52 escape parser: directed table, then random byte streams.
`default_nettype none
module vt52_escape_parser_tb;
  import vtp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_WAIT   = 18;    // longest gap or stall per transfer
  localparam int unsigned SETTLE     = 4;     // cycles to let a byte with no result retire
  localparam int unsigned STUCK_MAX  = 1000;  // cycles without any transfer
  localparam logic [APB_AW-1:0] ADDR_EXEC = APB_AW'({REG_EXECUTE_CONTROLS, 2'b00});

  typedef enum logic [1:0] {
    STEP_BYTE,     // send, expectation from the predictor
    STEP_CHECKED,  // send, expectation typed in the table
    STEP_CFG       // write execute_controls with val[0]
  } step_e;

  typedef struct packed {
    step_e       op;
    logic [7:0]  val;
    result_t     want;
  } step_t;

  localparam result_t NONE = '{KIND_PRINT, 7'h00, 4'h0, 5'd0, 7'd0};

  localparam int PLAN_LEN = 28;
  localparam step_t PLAN [PLAN_LEN] = '{
    '{STEP_CHECKED, 8'h00, '{KIND_CTRL_EX, 7'h00, 4'h0, 5'd0, 7'd0}},
    '{STEP_CHECKED, 8'h1f, '{KIND_CTRL_EX, 7'h1f, 4'h0, 5'd0, 7'd0}},
    '{STEP_CHECKED, 8'h20, '{KIND_PRINT,   7'h20, 4'h0, 5'd0, 7'd0}},
    '{STEP_BYTE,    8'hff, NONE},  // DEL with bit 7 set: dropped
    '{STEP_CHECKED, 8'h1b, '{KIND_CTRL_EX, 7'h1b, 4'h0, 5'd0, 7'd0}},
    '{STEP_CHECKED, 8'h1b, '{KIND_CTRL_EX, 7'h1b, 4'h0, 5'd0, 7'd0}},
    '{STEP_CHECKED, 8'h3c, '{KIND_COMMAND, 7'h00, CMD_VT100, 5'd0, 7'd0}},
    '{STEP_BYTE,    8'h1b, NONE},
    '{STEP_CHECKED, 8'h5a, '{KIND_COMMAND, 7'h00, CMD_IDENTIFY, 5'd0, 7'd0}},
    '{STEP_BYTE,    8'h1b, NONE},
    '{STEP_CHECKED, 8'h45, '{KIND_COMMAND, 7'h00, CMD_NOP, 5'd0, 7'd0}},
    '{STEP_BYTE,    8'h1b, NONE},
    '{STEP_BYTE,    8'h7f, NONE},  // DEL ends the escape
    '{STEP_BYTE,    8'h1b, NONE},
    '{STEP_BYTE,    8'h3b, NONE},  // just below the command letters
    '{STEP_BYTE,    8'h1b, NONE},
    '{STEP_BYTE,    8'h59, NONE},
    '{STEP_BYTE,    8'hff, NONE},  // row clamps to the bottom line
    '{STEP_BYTE,    8'h0d, NONE},  // control inside an address
    '{STEP_CHECKED, 8'h20, '{KIND_CURSOR, 7'h00, 4'h0, 5'd24, 7'd1}},
    '{STEP_BYTE,    8'h1b, NONE},
    '{STEP_BYTE,    8'hd9, NONE},
    '{STEP_BYTE,    8'h20, NONE},
    '{STEP_CHECKED, 8'hef, '{KIND_CURSOR, 7'h00, 4'h0, 5'd1, 7'd80}},
    '{STEP_CFG,     8'h00, NONE},
    '{STEP_CHECKED, 8'h9b, '{KIND_CTRL_DS, 7'h1b, 4'h0, 5'd0, 7'd0}},
    '{STEP_CHECKED, 8'h3c, '{KIND_PRINT,   7'h3c, 4'h0, 5'd0, 7'd0}},
    '{STEP_CFG,     8'h01, NONE}
  };

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [IN_W-1:0]   s_axis_tdata;   // rx_byte
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [OUT_W-1:0]  m_axis_tdata;   // char_code, command, row, column
  logic [KIND_W-1:0] m_axis_tuser;   // kind
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  // predictor state
  parse_e           pstate;
  logic [ROW_W-1:0] held_row;
  logic             exec_ctl;

  result_t     pending_results[$];
  result_t     oldest;
  bit          idle_on;
  int unsigned fails;
  int unsigned stuck_cycles;

  vt52_escape_parser dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [CMD_W-1:0] escape_command(input logic [CHAR_W-1:0] c);
    logic [CMD_W-1:0] cmd;
    case (c)
      7'h3c:   cmd = CMD_VT100;      // <
      7'h3d:   cmd = CMD_ALT_KP;     // =
      7'h3e:   cmd = CMD_NORM_KP;    // >
      7'h41:   cmd = CMD_UP;
      7'h42:   cmd = CMD_DOWN;
      7'h43:   cmd = CMD_RIGHT;
      7'h44:   cmd = CMD_LEFT;
      7'h46:   cmd = CMD_GFX_ON;
      7'h47:   cmd = CMD_GFX_OFF;
      7'h48:   cmd = CMD_HOME;
      7'h49:   cmd = CMD_REV_LF;
      7'h4a:   cmd = CMD_ERASE_EOS;
      7'h4b:   cmd = CMD_ERASE_EOL;
      7'h59:   cmd = CMD_ADDRESS;
      7'h5a:   cmd = CMD_IDENTIFY;
      default: cmd = CMD_NOP;
    endcase
    return cmd;
  endfunction

  // Advance the parser copy by one byte; returns 1 when a result is due.
  function automatic bit classify_byte(input logic [IN_W-1:0] rx, output result_t res);
    logic [CHAR_W-1:0] c;
    logic [CMD_W-1:0]  cmd;
    c = rx[CHAR_W-1:0];
    res = NONE;
    if (c < CH_SPACE) begin
      res.char_code = c;
      if (exec_ctl) begin
        res.kind = KIND_CTRL_EX;
        if (c == CH_ESC && pstate == ST_NORMAL) pstate = ST_ESCAPE;
      end else begin
        res.kind = KIND_CTRL_DS;
      end
      return 1'b1;
    end
    case (pstate)
      ST_NORMAL: begin
        if (c == CH_DEL) return 1'b0;
        res.kind = KIND_PRINT;
        res.char_code = c;
        return 1'b1;
      end
      ST_ESCAPE: begin
        pstate = ST_NORMAL;
        if (c < CH_LT || c > CH_Z) return 1'b0;
        cmd = escape_command(c);
        if (cmd == CMD_ADDRESS) begin
          pstate = ST_ROW;
          return 1'b0;
        end
        res.kind = KIND_COMMAND;
        res.command = cmd;
        return 1'b1;
      end
      ST_ROW: begin
        if (c > CH_ROW_MAX) c = CH_ROW_MAX;
        held_row = ROW_W'(c - ADDR_BIAS);
        pstate = ST_COLUMN;
        return 1'b0;
      end
      default: begin
        if (c > CH_COL_MAX) c = CH_COL_MAX;
        pstate = ST_NORMAL;
        res.kind = KIND_CURSOR;
        res.row = held_row;
        res.column = COL_W'(c - ADDR_BIAS);
        return 1'b1;
      end
    endcase
  endfunction

  function automatic logic [IN_W-1:0] with_b7(input logic [CHAR_W-1:0] c);
    logic top;
    top = 1'($urandom_range(1, 0));
    return {top, c};
  endfunction

  // Hold valid until the transfer, then run the predictor on the byte.
  task automatic transfer_byte(input logic [IN_W-1:0] b, output bit got, output result_t res);
    int unsigned gap;
    gap = idle_on ? $urandom_range(MAX_WAIT, 0) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(negedge clk_i);
    while (!s_axis_tready) @(negedge clk_i);
    @(posedge clk_i);
    got = classify_byte(b, res);
  endtask

  // Drain, then write execute_controls and read it back.
  task automatic write_exec(input logic v);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= ADDR_EXEC;
    pwdata  <= APB_DW'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    if (prdata[0] !== v) begin
      $error("execute_controls: expected %0d, got %0d", v, prdata[0]);
      fails++;
    end
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    exec_ctl = v;
  endtask

  // Mostly well-formed escapes and text with random content, some noise.
  task automatic build_sequence(output logic [IN_W-1:0] seq[$]);
    int unsigned pick;
    logic [CHAR_W-1:0] c;
    pick = $urandom_range(99, 0);
    seq = {};
    if (pick < 25) begin
      seq.push_back(with_b7(7'($urandom_range(7'h7f, 7'h20))));
    end else if (pick < 35) begin
      seq.push_back(with_b7(7'($urandom_range(7'h1f, 7'h00))));
    end else if (pick < 60) begin
      c = 7'($urandom_range(CH_Z, CH_LT));
      if (c == 7'h59) c = CH_Z;
      seq.push_back(with_b7(CH_ESC));
      seq.push_back(with_b7(c));
    end else if (pick < 85) begin
      seq.push_back(with_b7(CH_ESC));
      seq.push_back(with_b7(7'h59));
      if ($urandom_range(4, 0) == 0) seq.push_back(with_b7(7'($urandom_range(7'h7f, 7'h38))));
      else seq.push_back(with_b7(7'($urandom_range(7'h37, 7'h20))));
      if ($urandom_range(4, 0) == 0) seq.push_back(with_b7(7'($urandom_range(7'h1f, 7'h00))));
      if ($urandom_range(4, 0) == 0) seq.push_back(with_b7(7'($urandom_range(7'h7f, 7'h70))));
      else seq.push_back(with_b7(7'($urandom_range(7'h6f, 7'h20))));
    end else if (pick < 92) begin
      seq.push_back(with_b7(CH_ESC));
      if ($urandom_range(1, 0) == 1) seq.push_back(with_b7(7'($urandom_range(7'h3b, 7'h20))));
      else seq.push_back(with_b7(7'($urandom_range(7'h7f, 7'h5b))));
    end else begin
      seq.push_back(IN_W'($urandom_range(255, 0)));
    end
  endtask

  task automatic run_phase(input int unsigned n, input logic exec, input bit idle);
    logic [IN_W-1:0] seq[$];
    int unsigned sent;
    bit got;
    result_t res;
    write_exec(exec);
    idle_on = idle;
    sent = 0;
    while (sent < n) begin
      build_sequence(seq);
      foreach (seq[k]) begin
        transfer_byte(seq[k], got, res);
        if (got) pending_results.push_back(res);
        sent++;
      end
    end
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  // result side: random stall before each transfer when idle_on is set
  initial begin
    int unsigned stall;
    m_axis_tready = 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      stall = idle_on ? $urandom_range(MAX_WAIT, 0) : 0;
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(negedge clk_i);
      while (!m_axis_tvalid) @(negedge clk_i);
      @(posedge clk_i);
    end
  end

  // Signals are settled at the falling edge; a transfer seen here lands at the next rise.
  always @(negedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("result with no expectation: tuser %0d tdata %h", m_axis_tuser, m_axis_tdata);
        fails++;
      end else begin
        oldest = pending_results.pop_front();
        check_field("kind",      oldest.kind,      m_axis_tuser);
        check_field("char_code", oldest.char_code, m_axis_tdata[6:0]);
        check_field("command",   oldest.command,   m_axis_tdata[10:7]);
        check_field("row",       oldest.row,       m_axis_tdata[15:11]);
        check_field("column",    oldest.column,    m_axis_tdata[22:16]);
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
        if (stuck_cycles == STUCK_MAX) begin
          $display("tb: failure");
          $finish;
        end
      end
    end
  end

  initial begin
    bit got;
    result_t res;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    pstate        = ST_NORMAL;
    held_row      = '0;
    exec_ctl      = 1'b1;
    idle_on       = 1'b1;
    fails         = 0;
    stuck_cycles  = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (PLAN[i]) begin
      if (PLAN[i].op == STEP_CFG) begin
        s_axis_tvalid <= 1'b0;
        write_exec(PLAN[i].val[0]);
      end else begin
        transfer_byte(PLAN[i].val, got, res);
        if (PLAN[i].op == STEP_CHECKED) pending_results.push_back(PLAN[i].want);
        else if (got) pending_results.push_back(res);
      end
    end

    run_phase(300, 1'b1, 1'b1);
    run_phase(300, 1'b0, 1'b1);
    run_phase(300, 1'b1, 1'b0);
    run_phase(300, 1'b0, 1'b0);
    run_phase(300, 1'b1, 1'b1);

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (fails == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
`default_nettype wire
